FILE: rtl/core/qct_pkg.sv
`timescale 1ns / 1ps
// Shared types, character constants and the whitespace function of the tokenizer.
// Used by all modules of the quoted command tokenizer; depends on nothing.
package qct_pkg;

    localparam int CHAR_BITS_DEF = 8;
    localparam int CHAR_BITS_MAX = 16;
    localparam int RES_MAX       = 3;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_SEP  = 2'd2
    } t_kind;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } t_push;

    function automatic logic is_space(input logic [CHAR_BITS_MAX-1:0] c);
        is_space = (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 ||
                   c == 16'h0085 || c == 16'h00A0;
    endfunction

endpackage

FILE: rtl/core/qct_front.sv
`timescale 1ns / 1ps
// Front part: accepts characters, keeps the quoting state and builds result bundles.
// Depends on qct_pkg.
module qct_front #(
    parameter int CHAR_BITS = qct_pkg::CHAR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [CHAR_BITS-1:0]                  i_code,
    input  logic                                  i_end_of_text,
    input  logic                                  i_full,
    output qct_pkg::t_push                        o_push,
    output logic [qct_pkg::RES_MAX-1:0][1:0]      o_kinds,
    output logic [qct_pkg::RES_MAX-1:0][CHAR_BITS-1:0] o_values
);
    import qct_pkg::*;

    logic r_quoting, r_single_quoted, r_escape_pending, r_token_open;
    logic n_quoting, n_single_quoted, n_escape_pending, n_token_open;
    logic [1:0] res_cnt;
    logic do_plain;
    logic accept;
    logic [CHAR_BITS-1:0] c_semi, c_dq, c_sq, c_bs, closer;

    assign c_semi = CHAR_BITS'(CH_SEMI);
    assign c_dq   = CHAR_BITS'(CH_DQUOTE);
    assign c_sq   = CHAR_BITS'(CH_SQUOTE);
    assign c_bs   = CHAR_BITS'(CH_BSLASH);
    assign closer = r_single_quoted ? c_sq : c_dq;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_quoting        = r_quoting;
        n_single_quoted  = r_single_quoted;
        n_escape_pending = r_escape_pending;
        n_token_open     = r_token_open;
        res_cnt          = 2'd0;
        do_plain         = 1'b0;
        o_kinds          = '0;
        o_values         = '0;
        if (i_end_of_text) begin
            if (r_escape_pending) begin
                o_kinds[res_cnt]  = KIND_CHAR;
                o_values[res_cnt] = c_bs;
                res_cnt           = res_cnt + 2'd1;
            end
            if (r_escape_pending || r_token_open) begin
                o_kinds[res_cnt]  = KIND_END;
                o_values[res_cnt] = '0;
                res_cnt           = res_cnt + 2'd1;
            end
            n_quoting        = 1'b0;
            n_single_quoted  = 1'b0;
            n_escape_pending = 1'b0;
            n_token_open     = 1'b0;
        end else if (r_escape_pending) begin
            n_escape_pending = 1'b0;
            n_token_open     = 1'b1;
            if (i_code == c_dq || i_code == c_bs) begin
                o_kinds[res_cnt]  = KIND_CHAR;
                o_values[res_cnt] = i_code;
                res_cnt           = res_cnt + 2'd1;
            end else begin
                o_kinds[res_cnt]  = KIND_CHAR;
                o_values[res_cnt] = c_bs;
                res_cnt           = res_cnt + 2'd1;
                do_plain          = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (r_quoting) begin
                if (i_code == closer) begin
                    n_quoting = 1'b0;
                end else if (i_code == c_bs) begin
                    n_escape_pending = 1'b1;
                end else begin
                    o_kinds[res_cnt]  = KIND_CHAR;
                    o_values[res_cnt] = i_code;
                    res_cnt           = res_cnt + 2'd1;
                    n_token_open      = 1'b1;
                end
            end else if (is_space(CHAR_BITS_MAX'(i_code)) || i_code == c_semi) begin
                if (n_token_open) begin
                    o_kinds[res_cnt]  = KIND_END;
                    o_values[res_cnt] = '0;
                    res_cnt           = res_cnt + 2'd1;
                    n_token_open      = 1'b0;
                end
                if (i_code == c_semi) begin
                    o_kinds[res_cnt]  = KIND_SEP;
                    o_values[res_cnt] = c_semi;
                    res_cnt           = res_cnt + 2'd1;
                end
            end else if (i_code == c_dq || i_code == c_sq) begin
                n_quoting       = 1'b1;
                n_single_quoted = (i_code == c_sq);
            end else if (i_code == c_bs) begin
                n_escape_pending = 1'b1;
            end else begin
                o_kinds[res_cnt]  = KIND_CHAR;
                o_values[res_cnt] = i_code;
                res_cnt           = res_cnt + 2'd1;
                n_token_open      = 1'b1;
            end
        end
    end

    assign o_push.valid = accept && (res_cnt != 2'd0);
    assign o_push.count = res_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoting        <= 1'b0;
            r_single_quoted  <= 1'b0;
            r_escape_pending <= 1'b0;
            r_token_open     <= 1'b0;
        end else if (accept) begin
            r_quoting        <= n_quoting;
            r_single_quoted  <= n_single_quoted;
            r_escape_pending <= n_escape_pending;
            r_token_open     <= n_token_open;
        end
    end

endmodule

FILE: rtl/core/qct_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of result bundles between the front and back parts.
// Depends on qct_pkg.
module qct_queue #(
    parameter int CHAR_BITS = qct_pkg::CHAR_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  qct_pkg::t_push                             i_push,
    input  logic [qct_pkg::RES_MAX-1:0][1:0]           i_kinds,
    input  logic [qct_pkg::RES_MAX-1:0][CHAR_BITS-1:0] i_values,
    input  logic                                       i_pop,
    output logic                                       o_full,
    output logic                                       o_not_empty,
    output logic [1:0]                                 o_count,
    output logic [qct_pkg::RES_MAX-1:0][1:0]           o_kinds,
    output logic [qct_pkg::RES_MAX-1:0][CHAR_BITS-1:0] o_values
);
    import qct_pkg::*;

    logic [1:0]                          r_cnt    [2];
    logic [RES_MAX-1:0][1:0]             r_kinds  [2];
    logic [RES_MAX-1:0][CHAR_BITS-1:0]   r_values [2];
    logic r_wr, r_rd;
    logic [1:0] r_fill;
    logic do_pop;

    assign o_full      = (r_fill == 2'd2);
    assign o_not_empty = (r_fill != 2'd0);
    assign do_pop      = i_pop && o_not_empty;
    assign o_count     = r_cnt[r_rd];
    assign o_kinds     = r_kinds[r_rd];
    assign o_values    = r_values[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_cnt[r_wr]    <= i_push.count;
            r_kinds[r_wr]  <= i_kinds;
            r_values[r_wr] <= i_values;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push.valid && !do_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!i_push.valid && do_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/qct_back.sv
`timescale 1ns / 1ps
// Back part: sends the results of the head bundle one per transaction and marks the last.
// Depends on qct_pkg.
module qct_back #(
    parameter int CHAR_BITS = qct_pkg::CHAR_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_not_empty,
    input  logic [1:0]                                 i_count,
    input  logic [qct_pkg::RES_MAX-1:0][1:0]           i_kinds,
    input  logic [qct_pkg::RES_MAX-1:0][CHAR_BITS-1:0] i_values,
    output logic                                       o_pop,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [1:0]                                 o_kind,
    output logic [CHAR_BITS-1:0]                       o_value,
    output logic                                       o_last
);
    import qct_pkg::*;

    logic [1:0] r_idx;
    logic       take;

    assign o_valid = i_not_empty;
    assign o_kind  = i_kinds[r_idx];
    assign o_value = i_values[r_idx];
    assign o_last  = (r_idx == i_count - 2'd1);
    assign take    = o_valid && i_ready;
    assign o_pop   = take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (take) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

FILE: rtl/core/quoted_command_tokenizer_top.sv
`timescale 1ns / 1ps
// Top level of the quoted command tokenizer: front, bundle queue and back part.
// Depends on qct_pkg, qct_front, qct_queue and qct_back.
//
// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_ready   i_code, i_end_of_text
// output   out        o_valid / i_ready   o_kind, o_value, o_last
//
// A character's results are registered in the bundle queue and leave one per
// cycle while i_ready is high; the last result of each bundle is marked by o_last.
// The two-entry bundle queue lets input continue while results wait on i_ready.
// Reset is synchronous and clears the quoting state and the queue.
module quoted_command_tokenizer_top #(
    parameter int CHAR_BITS = qct_pkg::CHAR_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CHAR_BITS-1:0] i_code,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [CHAR_BITS-1:0] o_value,
    output logic                 o_last
);
    import qct_pkg::*;

    t_push                             push;
    logic [RES_MAX-1:0][1:0]           f_kinds, q_kinds;
    logic [RES_MAX-1:0][CHAR_BITS-1:0] f_values, q_values;
    logic                              q_full, q_not_empty, pop;
    logic [1:0]                        q_count;

    qct_front #(.CHAR_BITS(CHAR_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code        (i_code),
        .i_end_of_text (i_end_of_text),
        .i_full        (q_full),
        .o_push        (push),
        .o_kinds       (f_kinds),
        .o_values      (f_values)
    );

    qct_queue #(.CHAR_BITS(CHAR_BITS)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_kinds     (f_kinds),
        .i_values    (f_values),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_count     (q_count),
        .o_kinds     (q_kinds),
        .o_values    (q_values)
    );

    qct_back #(.CHAR_BITS(CHAR_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (q_not_empty),
        .i_count     (q_count),
        .i_kinds     (q_kinds),
        .i_values    (q_values),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

FILE: rtl/core/qct_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the quoted command tokenizer, bound to the top level.
// Depends on qct_pkg and quoted_command_tokenizer_top.
module qct_checker #(
    parameter int CHAR_BITS = qct_pkg::CHAR_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic [CHAR_BITS-1:0] i_code,
    input logic                 i_end_of_text,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [1:0]           o_kind,
    input logic [CHAR_BITS-1:0] o_value,
    input logic                 o_last
);
    import qct_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_value)
                                && $stable(o_last))
        else $error("Output transaction changed while stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("Block not idle after reset.");

    a_sep_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_SEP |-> o_last && o_value == CHAR_BITS'(CH_SEMI))
        else $error("Separator transaction malformed.");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_END |-> o_value == '0)
        else $error("End-of-token transaction carries a character.");

endmodule

bind quoted_command_tokenizer_top qct_checker #(.CHAR_BITS(CHAR_BITS)) u_qct_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of quoted_command_tokenizer_top: streams command strings and noise
// through the input channel and checks every output transaction against an internal predictor.
// Depends on qct_pkg and the tokenizer RTL.
module tb;
    import qct_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [7:0] code;
        logic       eot;
        logic       drain;
    } t_char_item;

    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       last;
    } t_token_out;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_code = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_last;

    t_char_item chars_to_send_q[$];
    t_token_out expected_q[$];

    bit         in_quote;
    bit         quote_single;
    bit         bslash_pending;
    bit         token_nonempty;

    int         n_total;
    int         n_accepted;
    int         mismatches;
    int         cycles;
    int         gap_left;
    int         burst_left;
    int         stall_mode;
    int         stall_cnt;
    t_char_item send_item;
    t_token_out seen;

    quoted_command_tokenizer_top #(
        .CHAR_BITS(8)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code        (i_code),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_blank(logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: is_blank = 1'b1;
            default: is_blank = 1'b0;
        endcase
    endfunction

    task automatic emit_token_out(t_kind k, logic [7:0] v);
        t_token_out r;
        r.kind  = k;
        r.value = v;
        r.last  = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic put_token_char(logic [7:0] c);
        emit_token_out(KIND_CHAR, c);
        token_nonempty = 1'b1;
    endtask

    task automatic close_token();
        if (token_nonempty) begin
            emit_token_out(KIND_END, 8'h00);
            token_nonempty = 1'b0;
        end
    endtask

    task automatic handle_unescaped(logic [7:0] c);
        logic [7:0] closer;
        closer = quote_single ? CH_SQUOTE : CH_DQUOTE;
        if (in_quote) begin
            if (c == closer) begin
                in_quote = 1'b0;
            end else if (c == CH_BSLASH) begin
                bslash_pending = 1'b1;
            end else begin
                put_token_char(c);
            end
        end else if (is_blank(c)) begin
            close_token();
        end else if (c == CH_SEMI) begin
            close_token();
            emit_token_out(KIND_SEP, CH_SEMI);
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            in_quote     = 1'b1;
            quote_single = (c == CH_SQUOTE);
        end else if (c == CH_BSLASH) begin
            bslash_pending = 1'b1;
        end else begin
            put_token_char(c);
        end
    endtask

    task automatic tokenize_item(logic [7:0] code, logic eot);
        int         n_before;
        t_token_out r;
        n_before = expected_q.size();
        if (eot) begin
            if (bslash_pending) put_token_char(CH_BSLASH);
            close_token();
            in_quote       = 1'b0;
            quote_single   = 1'b0;
            bslash_pending = 1'b0;
            token_nonempty = 1'b0;
        end else if (bslash_pending) begin
            bslash_pending = 1'b0;
            if (code == CH_DQUOTE || code == CH_BSLASH) begin
                put_token_char(code);
            end else begin
                put_token_char(CH_BSLASH);
                handle_unescaped(code);
            end
        end else begin
            handle_unescaped(code);
        end
        if (expected_q.size() > n_before) begin
            r = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
    endtask

    task automatic queue_char(logic [7:0] c, logic eot, logic drain);
        t_char_item it;
        it.code  = c;
        it.eot   = eot;
        it.drain = drain;
        chars_to_send_q.push_back(it);
    endtask

    function automatic logic [7:0] pick_command_char();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: pick_command_char = 8'h61 + 8'($urandom_range(0, 25));
            4:          pick_command_char = 8'h30 + 8'($urandom_range(0, 9));
            5, 6:       pick_command_char = 8'h20;
            7: begin
                case ($urandom_range(0, 3))
                    0: pick_command_char = 8'h09 + 8'($urandom_range(0, 4));
                    1: pick_command_char = 8'h85;
                    2: pick_command_char = 8'hA0;
                    default: pick_command_char = 8'h20;
                endcase
            end
            8:      pick_command_char = CH_SEMI;
            9:      pick_command_char = CH_DQUOTE;
            10:     pick_command_char = CH_SQUOTE;
            11, 12: pick_command_char = CH_BSLASH;
            13:     pick_command_char = 8'($urandom_range(0, 255));
            default: pick_command_char = 8'h41 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    // Driver: sends pending items in bursts; an item marked for draining waits until
    // every expected result has been seen.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid        <= 1'b0;
            i_code         <= 8'h00;
            i_end_of_text  <= 1'b0;
            in_quote       = 1'b0;
            quote_single   = 1'b0;
            bslash_pending = 1'b0;
            token_nonempty = 1'b0;
            gap_left       = 0;
            burst_left     = $urandom_range(1, 24);
        end else begin
            if (i_valid && o_ready) begin
                tokenize_item(i_code, i_end_of_text);
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (chars_to_send_q.size() == 0 ||
                             (chars_to_send_q[0].drain && expected_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    send_item = chars_to_send_q.pop_front();
                    i_valid       <= 1'b1;
                    i_code        <= send_item.code;
                    i_end_of_text <= send_item.eot;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_mode = 0;
            stall_cnt  = 0;
        end else begin
            stall_cnt++;
            if (stall_cnt % 48 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= (stall_cnt % 4 == 0);
                default: i_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: every output transaction is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected output kind=%0d value=%02h last=%0b",
                             o_kind, o_value, o_last);
                end
            end else begin
                seen = expected_q.pop_front();
                if (o_kind !== seen.kind || o_value !== seen.value || o_last !== seen.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: expected kind=%0d value=%02h last=%0b, %s",
                                 seen.kind, seen.value, seen.last, "got");
                        $display("       got kind=%0d value=%02h last=%0b",
                                 o_kind, o_value, o_last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int n_directed;
        int len;
        n_accepted = 0;
        mismatches = 0;
        cycles     = 0;

        queue_char("a", 1'b0, 1'b0);
        queue_char(CH_SEMI, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(CH_SEMI, 1'b0, 1'b0);
        queue_char(CH_DQUOTE, 1'b0, 1'b0);
        queue_char(8'h20, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(CH_DQUOTE, 1'b0, 1'b0);
        queue_char(CH_DQUOTE, 1'b0, 1'b0);
        queue_char(8'hA0, 1'b0, 1'b0);
        queue_char(CH_SQUOTE, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(CH_SQUOTE, 1'b0, 1'b0);
        queue_char(CH_DQUOTE, 1'b0, 1'b0);
        queue_char(CH_DQUOTE, 1'b0, 1'b0);
        queue_char(8'h85, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'h09, 1'b0, 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(CH_BSLASH, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b1, 1'b0);
        queue_char(CH_SQUOTE, 1'b0, 1'b1);
        queue_char("q", 1'b0, 1'b0);
        queue_char(8'h00, 1'b1, 1'b0);
        n_directed = chars_to_send_q.size();

        while (chars_to_send_q.size() < n_directed + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                len = $urandom_range(1, 20);
                for (int k = 0; k < len; k++) begin
                    queue_char(pick_command_char(), 1'b0,
                               chars_to_send_q.size() == n_directed ||
                               chars_to_send_q.size() == n_directed + RANDOM_ITEMS / 2);
                end
                queue_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0), 1'b0);
                end
            end
        end
        n_total = chars_to_send_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
